### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

### hw/rtl/cptm_pkg.sv
// ----------------------------------------------------------------------------
// cptm_pkg
// shared types and constants of the code point trie map builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cptm_pkg;

    localparam int STAGE2_WORDS_DEF    = 8192;
    localparam int BYTE_STORE_SIZE_DEF = 65536;

    localparam int S1_WORDS  = 32'h440;
    localparam int S2_BLOCK  = 32'h80;
    localparam int S2_CALC_W = 18;
    localparam int BASE_W    = 23;

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [12:0] S3_BLOCK_MAX = 13'h1FFF;

    localparam logic [1:0] CMD_INSERT     = 2'd0;
    localparam logic [1:0] CMD_READ_TRIE  = 2'd1;
    localparam logic [1:0] CMD_READ_BYTE  = 2'd2;

    localparam logic [1:0] PREC_PRECISE   = 2'd0;
    localparam logic [1:0] PREC_FALLBACK  = 2'd1;

    localparam logic [2:0] ST_WRITTEN     = 3'd0;
    localparam logic [2:0] ST_OVERWROTE   = 3'd1;
    localparam logic [2:0] ST_SKIPPED     = 3'd2;
    localparam logic [2:0] ST_DUP_ERROR   = 3'd3;
    localparam logic [2:0] ST_S2_FULL     = 3'd4;
    localparam logic [2:0] ST_S3_FULL     = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [20:0] code_point;
        logic [31:0] mapping_bytes;
        logic [2:0]  seq_length;
        logic [1:0]  precision;
        logic [15:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] read_data;
        logic [13:0] stage2_used;
        logic [15:0] stage3_used;
    } t_out_item;

endpackage

### hw/rtl/cptm_stream_if.sv
// ----------------------------------------------------------------------------
// cptm_stream_if
// valid/ready channel carrying one item per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cptm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/codepoint_trie_map_builder_core.sv
// ----------------------------------------------------------------------------
// codepoint_trie_map_builder_core
// insert: one item at a time; walks stage 1, stage 2 and the bitmap, then writes
//   the stored bytes, allocating and zeroing a stage-3 block first when needed
// reads: one item at a time, via S_READ and S_READ_DATA on the registered ram read ports
// reset: clearing pass over max(0x440 + STAGE2_WORDS, BYTE_STORE_SIZE) addresses
//   zeroes both rams, input ready stays low meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module codepoint_trie_map_builder_core #(
    parameter int STAGE2_WORDS    = cptm_pkg::STAGE2_WORDS_DEF,
    parameter int BYTE_STORE_SIZE = cptm_pkg::BYTE_STORE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata,
    cptm_stream_if.sink       i_in,
    cptm_stream_if.source     o_out
);

    import cptm_pkg::*;

`include "assert_macros.svh"

    localparam int TRIE_DEPTH = S1_WORDS + STAGE2_WORDS;
    localparam int TAW        = $clog2(TRIE_DEPTH);
    localparam int BAW        = $clog2(BYTE_STORE_SIZE);
    localparam int S2TW       = $clog2(STAGE2_WORDS + 1);
    localparam int CLR_LEN    = (TRIE_DEPTH > BYTE_STORE_SIZE) ? TRIE_DEPTH : BYTE_STORE_SIZE;
    localparam int CAW        = $clog2(CLR_LEN);

    localparam logic [S2TW-1:0] S2_LIMIT = S2TW'(STAGE2_WORDS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_S1,
        S_CHK_S1,
        S_S2_ADDR,
        S_CHK_S3,
        S_CLR,
        S_RD_BM,
        S_CHK_BM,
        S_WR_BYTES,
        S_READ,
        S_READ_DATA,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CAW-1:0]    r_init_cnt;
    logic [2:0]        r_mcl;
    logic [S2TW-1:0]   r_s2_top;
    logic [12:0]       r_s3_blocks;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [1:0]        r_cmd;
    logic [20:0]       r_cp;
    logic [31:0]       r_val;
    logic [1:0]        r_prec;
    logic [15:0]       r_addr;
    logic [15:0]       r_s1val;
    logic [TAW-1:0]    r_s2;
    logic [15:0]       r_s3blk;
    logic [BASE_W-1:0] r_base;
    logic [1:0]        r_k;
    logic [BAW-1:0]    r_clr_addr;
    logic [5:0]        r_clr_cnt;
    logic [2:0]        r_status;
    logic [15:0]       r_rdata;

    logic                 trie_we;
    logic [TAW-1:0]       trie_waddr;
    logic [15:0]          trie_wdata;
    logic [TAW-1:0]       trie_raddr;
    logic [15:0]          tw_q;
    logic                 bs_we;
    logic [BAW-1:0]       bs_waddr;
    logic [7:0]           bs_wdata;
    logic [BAW-1:0]       bs_raddr;
    logic [7:0]           bs_q;

    logic [2:0]           len;
    logic [5:0]           blk_m1;
    logic                 s2_full;
    logic [S2_CALC_W-1:0] s2_calc;
    logic                 s2_oob;
    logic                 s3_full;
    logic [BASE_W-1:0]    s3_next_bytes;
    logic [BASE_W-1:0]    clr_start;
    logic [15:0]          bit_mask;
    logic                 assigned;
    logic                 bm_write;
    logic [BASE_W-1:0]    base_calc;
    logic [BASE_W-1:0]    wr_addr;
    logic                 wr_in_range;
    logic [1:0]           byte_idx;
    logic [2:0]           len_m1;
    logic [19:0]          s3_bytes;
    logic [31:0]          in_val;

    // effective stored length
    always_comb begin
        case (r_mcl) inside
            3'd0:          len = 3'd1;
            [3'd1:3'd4]:   len = r_mcl;
            default:       len = 3'd4;
        endcase
    end

    // sequence value masked to its length
    always_comb begin
        case (i_in.data.seq_length)
            3'd0:    in_val = 32'h0;
            3'd1:    in_val = i_in.data.mapping_bytes & 32'h0000_00FF;
            3'd2:    in_val = i_in.data.mapping_bytes & 32'h0000_FFFF;
            3'd3:    in_val = i_in.data.mapping_bytes & 32'h00FF_FFFF;
            default: in_val = i_in.data.mapping_bytes;
        endcase
    end

    assign len_m1        = len - 3'd1;
    assign blk_m1        = 6'(7'({len, 4'b0000}) - 7'd1);
    assign s2_full       = ((S2TW + 1)'(r_s2_top) + (S2TW + 1)'(S2_BLOCK))
                           > (S2TW + 1)'(STAGE2_WORDS);
    assign s2_calc       = S2_CALC_W'(S1_WORDS)
                           + ((S2_CALC_W'(r_s1val) + S2_CALC_W'(r_cp[9:4])) << 1);
    assign s2_oob        = s2_calc >= S2_CALC_W'(TRIE_DEPTH - 1);
    assign s3_next_bytes = BASE_W'({({1'b0, r_s3_blocks} + 14'd1), 4'b0000})
                           * BASE_W'(len);
    assign s3_full       = (r_s3_blocks >= S3_BLOCK_MAX)
                           || (s3_next_bytes >= BASE_W'(BYTE_STORE_SIZE));
    assign clr_start     = BASE_W'({r_s3_blocks, 4'b0000}) * BASE_W'(len);
    assign bit_mask      = 16'(1) << r_cp[3:0];
    assign assigned      = tw_q[r_cp[3:0]];
    assign bm_write      = (r_prec != PREC_FALLBACK)
                           && !(assigned && (r_prec == PREC_PRECISE));
    assign base_calc     = BASE_W'({r_s3blk, r_cp[3:0]}) * BASE_W'(len);
    assign wr_addr       = r_base + BASE_W'(r_k);
    assign wr_in_range   = wr_addr < BASE_W'(BYTE_STORE_SIZE);
    assign byte_idx      = 2'(len_m1 - {1'b0, r_k});
    assign s3_bytes      = 20'({r_s3_blocks, 4'b0000}) * 20'(len);

    // memory port control
    always_comb begin
        trie_we    = 1'b0;
        trie_waddr = '0;
        trie_wdata = '0;
        trie_raddr = '0;
        bs_we      = 1'b0;
        bs_waddr   = '0;
        bs_wdata   = '0;
        bs_raddr   = '0;
        case (r_state)
            S_INIT: begin
                trie_we    = 32'(r_init_cnt) < 32'(TRIE_DEPTH);
                trie_waddr = r_init_cnt[TAW-1:0];
                bs_we      = 32'(r_init_cnt) < 32'(BYTE_STORE_SIZE);
                bs_waddr   = r_init_cnt[BAW-1:0];
            end
            S_RD_S1: begin
                trie_raddr = TAW'(r_cp[20:10]);
            end
            S_CHK_S1: begin
                trie_we    = (tw_q == 16'h0) && !s2_full;
                trie_waddr = TAW'(r_cp[20:10]);
                trie_wdata = 16'(r_s2_top >> 1);
            end
            S_S2_ADDR: begin
                trie_raddr = TAW'(s2_calc + S2_CALC_W'(1));
            end
            S_CHK_S3: begin
                trie_we    = (tw_q == 16'h0) && !s3_full;
                trie_waddr = r_s2 + TAW'(1);
                trie_wdata = 16'(r_s3_blocks);
            end
            S_CLR: begin
                bs_we    = 1'b1;
                bs_waddr = r_clr_addr;
            end
            S_RD_BM: begin
                trie_raddr = r_s2;
            end
            S_CHK_BM: begin
                trie_we    = bm_write;
                trie_waddr = r_s2;
                trie_wdata = tw_q | bit_mask;
            end
            S_WR_BYTES: begin
                bs_we    = wr_in_range;
                bs_waddr = wr_addr[BAW-1:0];
                bs_wdata = r_val[{byte_idx, 3'b000} +: 8];
            end
            S_READ: begin
                trie_raddr = TAW'(r_addr);
                bs_raddr   = BAW'(r_addr);
            end
            default: begin
            end
        endcase
    end

    cptm_ram #(
        .DEPTH (TRIE_DEPTH),
        .WIDTH (16)
    ) u_trie_ram (
        .i_clk     (i_clk),
        .i_we      (trie_we),
        .i_wr_addr (trie_waddr),
        .i_wr_data (trie_wdata),
        .i_rd_addr (trie_raddr),
        .o_rd_data (tw_q)
    );

    cptm_ram #(
        .DEPTH (BYTE_STORE_SIZE),
        .WIDTH (8)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_we      (bs_we),
        .i_wr_addr (bs_waddr),
        .i_wr_data (bs_wdata),
        .i_rd_addr (bs_raddr),
        .o_rd_data (bs_q)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_mcl       <= 3'd1;
            r_s2_top    <= S2TW'(S2_BLOCK);
            r_s3_blocks <= 13'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mcl <= i_cfg_wdata;
            end
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_cnt <= r_init_cnt + CAW'(1);
                    if (r_init_cnt == CAW'(CLR_LEN - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd    <= i_in.data.cmd;
                        r_cp     <= i_in.data.code_point;
                        r_val    <= in_val;
                        r_prec   <= i_in.data.precision;
                        r_addr   <= i_in.data.read_address;
                        r_status <= ((i_in.data.cmd == CMD_INSERT)
                                     && (i_in.data.code_point > CP_MAX))
                                    ? ST_SKIPPED : ST_WRITTEN;
                        r_rdata  <= 16'h0;
                        case (i_in.data.cmd)
                            CMD_INSERT: begin
                                if (i_in.data.code_point > CP_MAX) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD_S1;
                                end
                            end
                            CMD_READ_TRIE: begin
                                if (32'(i_in.data.read_address) < 32'(TRIE_DEPTH)) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            CMD_READ_BYTE: begin
                                if (32'(i_in.data.read_address) < 32'(BYTE_STORE_SIZE)) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_S1: begin
                    r_state <= S_CHK_S1;
                end
                S_CHK_S1: begin
                    if (tw_q == 16'h0) begin
                        if (s2_full) begin
                            r_status <= ST_S2_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_s1val  <= 16'(r_s2_top >> 1);
                            r_s2_top <= r_s2_top + S2TW'(S2_BLOCK);
                            r_state  <= S_S2_ADDR;
                        end
                    end else begin
                        r_s1val <= tw_q;
                        r_state <= S_S2_ADDR;
                    end
                end
                S_S2_ADDR: begin
                    r_s2 <= TAW'(s2_calc);
                    if (s2_oob) begin
                        r_status <= ST_S2_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CHK_S3;
                    end
                end
                S_CHK_S3: begin
                    if (tw_q == 16'h0) begin
                        if (s3_full) begin
                            r_status <= ST_S3_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_s3blk     <= 16'(r_s3_blocks);
                            r_s3_blocks <= r_s3_blocks + 13'd1;
                            r_clr_addr  <= clr_start[BAW-1:0];
                            r_clr_cnt   <= 6'd0;
                            r_state     <= S_CLR;
                        end
                    end else begin
                        r_s3blk <= tw_q;
                        r_state <= S_RD_BM;
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + BAW'(1);
                    r_clr_cnt  <= r_clr_cnt + 6'd1;
                    if (r_clr_cnt == blk_m1) begin
                        r_state <= S_RD_BM;
                    end
                end
                S_RD_BM: begin
                    r_state <= S_CHK_BM;
                end
                S_CHK_BM: begin
                    r_base <= base_calc;
                    r_k    <= 2'd0;
                    if (r_prec == PREC_FALLBACK) begin
                        if (assigned) begin
                            r_status <= ST_SKIPPED;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_WR_BYTES;
                        end
                    end else if (assigned && (r_prec == PREC_PRECISE)) begin
                        r_status <= ST_DUP_ERROR;
                        r_state  <= S_DONE;
                    end else begin
                        r_status <= assigned ? ST_OVERWROTE : ST_WRITTEN;
                        r_state  <= S_WR_BYTES;
                    end
                end
                S_WR_BYTES: begin
                    r_k <= r_k + 2'd1;
                    if ({1'b0, r_k} == len_m1) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_state <= S_READ_DATA;
                end
                S_READ_DATA: begin
                    r_rdata <= (r_cmd == CMD_READ_TRIE) ? tw_q : 16'(bs_q);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid       <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.read_data   <= r_rdata;
                        r_out.stage2_used <= 14'(r_s2_top);
                        r_out.stage3_used <= s3_bytes[15:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_INIT, !i_in.ready, "input accepted during clearing pass")
    `ASSERT_IMPLIES(a_no_result_in_clear, i_clk, i_rst_n, r_state == S_INIT, !r_out_valid, "result shown during clearing pass")
    `ASSERT_IMPLIES(a_s2_top_bound, i_clk, i_rst_n, 1'b1, r_s2_top <= S2_LIMIT, "stage-2 allocation beyond store")
    `ASSERT_NEXT(a_s3_step, i_clk, i_rst_n, 1'b1, (r_s3_blocks == $past(r_s3_blocks)) || (r_s3_blocks == $past(r_s3_blocks) + 1), "stage-3 block count jumped")

endmodule

### hw/rtl/cptm_ram.sv
// ----------------------------------------------------------------------------
// cptm_ram
// single-port-write, single-port-read synchronous ram, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cptm_ram #(
    parameter int  DEPTH = cptm_pkg::BYTE_STORE_SIZE_DEF,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
